// ----- rtl/ipv4dq_pkg.sv -----
package ipv4dq_pkg;

  // Text constants
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // Number rules
  localparam int unsigned OCTET_MAX    = 255;
  localparam int unsigned DECIMAL_BASE = 10;
  localparam int unsigned DOTS_NEEDED  = 3;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_OVER = 3'd1,
    ERR_DOTS = 3'd2,
    ERR_CHAR = 3'd3,
    ERR_FEW  = 3'd4
  } error_kind_t;

  // Parse state carried from one character to the next
  typedef struct packed {
    logic [7:0]      acc;
    logic [1:0]      dots;
    logic [2:0][7:0] octets;
    error_kind_t     err;
  } parse_state_t;

  // Outcome of one string
  typedef struct packed {
    logic        ok;
    logic [31:0] value;
    error_kind_t kind;
  } parse_result_t;

endpackage

// ----- rtl/ipv4dq_if.sv -----
// Character stream: one text byte per beat, or an end-of-text beat
interface ipv4dq_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, text_char, end_of_text, input ready);
  modport sink   (input valid, text_char, end_of_text, output ready);
endinterface

// Parse outcome: one beat per string
interface ipv4dq_result_if;
  logic        valid;
  logic        ready;
  logic        parse_ok;
  logic [31:0] ipv4_value;
  logic [2:0]  error_kind;

  modport source (output valid, parse_ok, ipv4_value, error_kind, input ready);
  modport sink   (input valid, parse_ok, ipv4_value, error_kind, output ready);
endinterface

// ----- rtl/ipv4dq_step.sv -----
// Next parse state for one character, and the outcome on end of text
module ipv4dq_step (
  input  ipv4dq_pkg::parse_state_t  state,
  input  logic [7:0]                text_char,
  input  logic                      end_of_text,
  output ipv4dq_pkg::parse_state_t  state_next,
  output ipv4dq_pkg::parse_result_t outcome
);
  import ipv4dq_pkg::*;

  logic [7:0]  digit;
  logic [11:0] acc_next;
  error_kind_t final_err;

  // acc * 10 + digit; at most 2559, so 12 bits
  assign digit    = text_char - CHAR_ZERO;
  assign acc_next = {4'b0, state.acc} * 12'(DECIMAL_BASE) + {4'b0, digit};

  // Outcome at end of text: sticky error wins, then the dot count
  always_comb begin
    final_err = state.err;
    if (state.err == ERR_NONE && state.dots != 2'(DOTS_NEEDED)) begin
      final_err = ERR_FEW;
    end
    outcome.ok    = (final_err == ERR_NONE);
    outcome.kind  = final_err;
    outcome.value = (final_err == ERR_NONE) ? {state.acc, state.octets} : 32'd0;
  end

  // State update
  always_comb begin
    state_next = state;
    if (end_of_text) begin
      state_next = '0;
    end else if (state.err == ERR_NONE) begin
      if (text_char >= CHAR_ZERO && text_char <= CHAR_NINE) begin
        if (acc_next > 12'(OCTET_MAX)) begin
          state_next.err = ERR_OVER;
        end else begin
          state_next.acc = acc_next[7:0];
        end
      end else if (text_char == CHAR_DOT) begin
        if (state.dots == 2'(DOTS_NEEDED)) begin
          state_next.err = ERR_DOTS;
        end else begin
          state_next.octets[state.dots] = state.acc;
          state_next.dots               = state.dots + 2'd1;
          state_next.acc                = '0;
        end
      end else begin
        state_next.err = ERR_CHAR;
      end
    end
  end

endmodule

// ----- rtl/ipv4_dotted_quad_parser.sv -----
// IPv4 dotted-decimal parser. Feed the address text one character per beat on
// chars, then one beat with end_of_text set (its text_char is ignored). One
// beat is taken every cycle unless an end-of-text beat waits in the input
// register; the character update (multiply by ten, add, range check, dot
// bookkeeping) is a combinational step on the parse state, so the rate is one
// character per clock while nothing waits. The end-of-text beat passes through
// the input register and then the result register, which loads the outcome
// when the end-of-text beat advances, and raises result.valid. A result
// waiting on a stalled sink does not stop characters of the next string; only
// a further end-of-text beat waits in the input register for the result
// register to free, and it holds off the beats behind it while it waits.
// parse_ok is 1 with the packed address (first octet in bits 7..0), or 0 with
// ipv4_value zero and the first error seen: 1 octet over 255, 2 too many dots,
// 3 invalid character, 4 too few dots. Empty octets read as zero and leading
// zeros are accepted.
module ipv4_dotted_quad_parser (
  input  logic                   clk,
  input  logic                   rst,
  ipv4dq_char_if.sink            chars,
  ipv4dq_result_if.source        result
);
  import ipv4dq_pkg::*;

  logic          s1_valid;
  logic [7:0]    s1_char;
  logic          s1_end;
  logic          advance;
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t outcome;
  logic          res_valid;
  parse_result_t res;

  // Input stage moves on unless it holds an end beat and the result is stuck
  assign advance     = s1_valid && (!s1_end || !res_valid || result.ready);
  assign chars.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      s1_char <= chars.text_char;
      s1_end  <= chars.end_of_text;
    end
  end

  ipv4dq_step u_step (
    .state       (state),
    .text_char   (s1_char),
    .end_of_text (s1_end),
    .state_next  (state_next),
    .outcome     (outcome)
  );

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && s1_end) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (advance && s1_end) begin
      res <= outcome;
    end
  end

  assign result.valid      = res_valid;
  assign result.parse_ok   = res.ok;
  assign result.ipv4_value = res.value;
  assign result.error_kind = res.kind;

endmodule

// ----- rtl/ipv4dq_checker.sv -----
// Port-level checks on the result channel
module ipv4dq_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        parse_ok,
  input logic [31:0] ipv4_value,
  input logic [2:0]  error_kind
);
  import ipv4dq_pkg::*;

  // A stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(parse_ok) && $stable(ipv4_value)
                        && $stable(error_kind))
    else $error("result beat changed while stalled");

  // Success carries no error code
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    valid && parse_ok |-> error_kind == ERR_NONE)
    else $error("parse_ok with an error code");

  // Failure carries a code and a zero address
  a_fail: assert property (@(posedge clk) disable iff (rst)
    valid && !parse_ok |-> error_kind != ERR_NONE && ipv4_value == 32'd0)
    else $error("failed parse without code or with nonzero address");

endmodule

bind ipv4_dotted_quad_parser ipv4dq_checker u_ipv4dq_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (result.valid),
  .ready      (result.ready),
  .parse_ok   (result.parse_ok),
  .ipv4_value (result.ipv4_value),
  .error_kind (result.error_kind)
);
